// ===== design/rbl_pkg.sv =====
// Shared types, constants and helper functions for the resource block locator.
// No dependencies; used by every module under design/.
`default_nettype none

package rbl_pkg;

    // Internal position and length width (default)
    localparam int LENGTH_BITS_DEF = 16;

    localparam int BUF_LEN_W = 16;
    localparam int TAG_W     = 16;
    localparam int HDR_W     = 9;
    localparam int DSIZE_W   = 16;
    localparam int DECL_W    = 32;

    localparam logic [TAG_W-1:0] TAG_RESET  = 16'h0404;
    localparam int               MIN_RECORD = 14;
    localparam int               HDR_FIXED  = 10;

    // APB register map
    localparam int        ADDR_W       = 3;
    localparam int        DATA_W       = 32;
    localparam logic      REG_IDX_TAG  = 1'b0;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_BYTE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_BAD   = 2'd1,
        STATUS_NONE  = 2'd2
    } t_status;

    typedef struct packed {
        t_action              action;
        logic [7:0]           data_byte;
        logic [BUF_LEN_W-1:0] buffer_length;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [15:0]          record_offset;
        logic [HDR_W-1:0]     header_size;
        logic [DSIZE_W-1:0]   data_size;
    } t_result;

    // Signature "8BIM", one byte per field position
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h38;
            2'd1: b = 8'h42;
            2'd2: b = 8'h49;
            2'd3: b = 8'h4D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/rbl_cfg.sv =====
// APB-style configuration register file: holds the target resource tag.
// Depends on rbl_pkg.
`default_nettype none

module rbl_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rbl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rbl_pkg::DATA_W-1:0]  pwdata,
    output logic      [rbl_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [rbl_pkg::TAG_W-1:0]   o_target_tag
);

    logic [rbl_pkg::TAG_W-1:0] r_target_tag;
    logic                      hit_tag;

    // Word index is the upper address bit; the low bits are not decoded
    assign hit_tag = (paddr[rbl_pkg::ADDR_W-1] == rbl_pkg::REG_IDX_TAG);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_tag <= rbl_pkg::TAG_RESET;
        end else if (psel && penable && pwrite && hit_tag) begin
            r_target_tag <= pwdata[rbl_pkg::TAG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit_tag) begin
            prdata = {{(rbl_pkg::DATA_W-rbl_pkg::TAG_W){1'b0}}, r_target_tag};
        end
    end

    assign o_target_tag = r_target_tag;

endmodule

`default_nettype wire

// ===== design/rbl_in_stage.sv =====
// Input register: captures one item per cycle unless stalled, and holds it until the parser takes it.
// Depends on rbl_pkg.
`default_nettype none

module rbl_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire rbl_pkg::t_in_item i_item,
    input  wire logic              i_consume,
    output logic                   o_valid,
    output rbl_pkg::t_in_item      o_item
);

    logic              r_valid;
    rbl_pkg::t_in_item r_item;
    logic              load;

    // Hold while a captured item waits for the parser
    assign o_stall = r_valid && !i_consume;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_consume) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== design/rbl_parser.sv =====
// Record parser: per-byte state machine and the result register.
// Depends on rbl_pkg.
`default_nettype none

module rbl_parser #(
    parameter int LENGTH_BITS = rbl_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [rbl_pkg::TAG_W-1:0] i_target_tag,
    input  wire logic                      i_valid,
    input  wire rbl_pkg::t_in_item         i_item,
    output logic                           o_consume,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output rbl_pkg::t_result               o_result
);

    localparam int LB = LENGTH_BITS;
    localparam int WN = LB + 10;
    localparam int WP = rbl_pkg::DECL_W + 2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SIG      = 3'd1,
        PH_TYPE     = 3'd2,
        PH_NAMELEN  = 3'd3,
        PH_NAMESKIP = 3'd4,
        PH_SIZE     = 3'd5,
        PH_DATASKIP = 3'd6
    } t_phase;

    t_phase                             r_phase,  n_phase;
    logic [LB-1:0]                      r_pos,    n_pos;
    logic [LB-1:0]                      r_total,  n_total;
    logic [1:0]                         r_fcnt,   n_fcnt;
    logic [rbl_pkg::TAG_W-1:0]          r_type,   n_type;
    logic [rbl_pkg::HDR_W-1:0]          r_pname,  n_pname;
    logic [rbl_pkg::DECL_W-1:0]         r_decl,   n_decl;
    logic [LB-1:0]                      r_skip,   n_skip;
    logic [LB-1:0]                      r_start,  n_start;
    logic                               r_out_valid, n_out_valid;
    rbl_pkg::t_result                   r_result, n_result;
    logic                               n_res_valid;

    logic [LB-1:0]                      pos_inc;
    logic [LB-1:0]                      remain;
    logic [31:0]                        len_ext;
    logic [rbl_pkg::HDR_W-1:0]          pname_calc;
    logic [rbl_pkg::DECL_W-1:0]         decl_shift;
    logic [rbl_pkg::DECL_W:0]           pad;
    logic [LB-1:0]                      skip_dec;

    assign pos_inc    = r_pos + LB'(1);
    assign remain     = r_total - pos_inc;
    assign len_ext    = {16'b0, i_item.buffer_length};
    assign pname_calc = (rbl_pkg::HDR_W'(i_item.data_byte) + rbl_pkg::HDR_W'(2))
                        & 9'h1FE;
    assign decl_shift = {r_decl[rbl_pkg::DECL_W-9:0], i_item.data_byte};
    assign pad        = (rbl_pkg::DECL_W+1)'(decl_shift)
                        + (rbl_pkg::DECL_W+1)'(decl_shift[0]);
    assign skip_dec   = (r_skip != '0) ? (r_skip - LB'(1)) : r_skip;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_total     = r_total;
        n_fcnt      = r_fcnt;
        n_type      = r_type;
        n_pname     = r_pname;
        n_decl      = r_decl;
        n_skip      = r_skip;
        n_start     = r_start;
        n_res_valid = 1'b0;
        n_result    = '{status: rbl_pkg::STATUS_NONE, record_offset: '0,
                        header_size: '0, data_size: '0};

        if (i_item.action == rbl_pkg::ACT_START) begin
            n_total = len_ext[LB-1:0];
            n_pos   = '0;
            n_start = '0;
            n_fcnt  = '0;
            n_type  = '0;
            n_pname = '0;
            n_decl  = '0;
            n_skip  = '0;
            if (WN'(len_ext[LB-1:0]) < WN'(rbl_pkg::MIN_RECORD)) begin
                n_res_valid = 1'b1;
                n_phase     = PH_IDLE;
            end else begin
                n_phase = PH_SIG;
            end
        end else if (r_phase != PH_IDLE) begin
            n_pos = pos_inc;
            unique case (r_phase)
                PH_SIG: begin
                    if (i_item.data_byte != rbl_pkg::sig_byte(r_fcnt)) begin
                        n_res_valid = 1'b1;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_fcnt = r_fcnt + 2'd1;
                        if (r_fcnt == 2'd3) begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    n_type = {r_type[7:0], i_item.data_byte};
                    if (r_fcnt == 2'd1) begin
                        n_fcnt  = '0;
                        n_phase = PH_NAMELEN;
                    end else begin
                        n_fcnt = r_fcnt + 2'd1;
                    end
                end
                PH_NAMELEN: begin
                    n_pname = pname_calc;
                    if (WN'(r_pos) + WN'(pname_calc) + WN'(4) > WN'(r_total)) begin
                        n_res_valid     = 1'b1;
                        n_result.status = rbl_pkg::STATUS_BAD;
                        n_phase         = PH_IDLE;
                    end else begin
                        n_skip  = LB'(pname_calc - rbl_pkg::HDR_W'(1));
                        n_fcnt  = '0;
                        n_phase = PH_NAMESKIP;
                    end
                end
                PH_NAMESKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_decl = decl_shift;
                    n_fcnt = r_fcnt + 2'd1;
                    if (r_fcnt == 2'd3) begin
                        n_fcnt = '0;
                        if (WP'(decl_shift) > WP'(remain)) begin
                            n_res_valid     = 1'b1;
                            n_result.status = rbl_pkg::STATUS_BAD;
                            n_phase         = PH_IDLE;
                        end else if (r_type == i_target_tag) begin
                            n_res_valid            = 1'b1;
                            n_result.status        = rbl_pkg::STATUS_FOUND;
                            n_result.record_offset = 16'(WN'(r_start));
                            n_result.header_size   = r_pname
                                                     + rbl_pkg::HDR_W'(rbl_pkg::HDR_FIXED);
                            n_result.data_size     = decl_shift[rbl_pkg::DSIZE_W-1:0];
                            n_phase                = PH_IDLE;
                        end else if (WP'(pad) + WP'(rbl_pkg::MIN_RECORD) > WP'(remain)) begin
                            n_res_valid = 1'b1;
                            n_phase     = PH_IDLE;
                        end else if (pad == '0) begin
                            n_start = pos_inc;
                            n_phase = PH_SIG;
                        end else begin
                            n_skip  = pad[LB-1:0];
                            n_phase = PH_DATASKIP;
                        end
                    end
                end
                PH_DATASKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_start = pos_inc;
                        n_fcnt  = '0;
                        n_phase = PH_SIG;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Take the item unless it makes a result and the result register is still full
    assign o_consume = i_valid && (!n_res_valid || !r_out_valid || !i_out_stall);

    // Load a new verdict, or hold the waiting one while the receiver stalls
    assign n_out_valid = (o_consume && n_res_valid) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_total     <= '0;
            r_fcnt      <= '0;
            r_type      <= '0;
            r_pname     <= '0;
            r_decl      <= '0;
            r_skip      <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_consume) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_total <= n_total;
                r_fcnt  <= n_fcnt;
                r_type  <= n_type;
                r_pname <= n_pname;
                r_decl  <= n_decl;
                r_skip  <= n_skip;
                r_start <= n_start;
                if (n_res_valid) begin
                    r_result <= n_result;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ===== design/resource_block_locator_unit.sv =====
// Top level of the resource block locator: input stage, record parser, config port.
// Depends on rbl_pkg, rbl_cfg, rbl_in_stage and rbl_parser.
//
// Usage:
//   Send a start item (action 0) carrying the buffer length, then the buffer
//   one byte per item (action 1). Exactly one verdict item comes out per
//   buffer: found (with record offset, header size and data size), malformed,
//   or no matching record. Bytes that arrive after the verdict are dropped
//   until the next start item; a start item in mid-buffer drops the open
//   buffer without a verdict.
//   Both channels use valid/stall: an item moves at a rising edge where valid
//   is high and stall is low.
//   Each accepted item is held in the input register; the parser works on it
//   there, and a verdict is loaded into the result register, from which the
//   receiver takes it. Throughput: one item per cycle, set by the single-pass
//   parser between the input register and the result register, except while
//   the input stalls as described below.
//   When the receiver stalls, the verdict holds in the result register;
//   items that give no verdict keep flowing, and the input stalls only when
//   the next item would produce a second verdict.
//   Reset (synchronous, active low) empties both registers, puts the parser
//   idle with no buffer open, and sets target_tag to 0x0404.
//   target_tag sits at APB byte address 0; the user must write it only while idle (not enforced).
`default_nettype none

module resource_block_locator_unit #(
    parameter int LENGTH_BITS = rbl_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // Config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rbl_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rbl_pkg::DATA_W-1:0]    pwdata,
    output logic      [rbl_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,

    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [rbl_pkg::BUF_LEN_W-1:0] i_buffer_length,

    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [15:0]                        o_record_offset,
    output logic [rbl_pkg::HDR_W-1:0]          o_header_size,
    output logic [rbl_pkg::DSIZE_W-1:0]        o_data_size
);

    logic [rbl_pkg::TAG_W-1:0] target_tag;
    rbl_pkg::t_in_item         in_item;
    rbl_pkg::t_in_item         stage_item;
    logic                      stage_valid;
    logic                      consume;
    rbl_pkg::t_result          result;

    // Pack the input fields into one item
    assign in_item.action        = rbl_pkg::t_action'(i_action);
    assign in_item.data_byte     = i_data_byte;
    assign in_item.buffer_length = i_buffer_length;

    rbl_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_target_tag (target_tag)
    );

    rbl_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_consume (consume),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    rbl_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target_tag (target_tag),
        .i_valid      (stage_valid),
        .i_item       (stage_item),
        .o_consume    (consume),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    // Unpack the verdict onto the result ports
    assign o_status        = result.status;
    assign o_record_offset = result.record_offset;
    assign o_header_size   = result.header_size;
    assign o_data_size     = result.data_size;

endmodule

`default_nettype wire

// ===== tb/resource_block_locator_unit_tb.sv =====
// Self-checking testbench for resource_block_locator_unit: builds record buffers,
// streams them byte by byte and checks every verdict against a local parser model.
// Depends on rbl_pkg and the design files under design/.
`default_nettype none

module resource_block_locator_unit_tb;

    // Long receiver hold-off used to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT      = 4000;
    // Two register stages between an accepted item and its verdict, plus margin
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;
    localparam logic [rbl_pkg::ADDR_W-1:0] TAG_ADDR =
        rbl_pkg::ADDR_W'(4 * int'(rbl_pkg::REG_IDX_TAG));
    localparam logic [7:0] SIG_BYTES [4] = '{8'h38, 8'h42, 8'h49, 8'h4D};

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SIG,
        SCAN_TYPE,
        SCAN_NAMELEN,
        SCAN_NAMESKIP,
        SCAN_SIZE,
        SCAN_DATASKIP
    } t_scan;

    logic                          clk = 1'b0;
    logic                          rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rbl_pkg::ADDR_W-1:0]    paddr;
    logic [rbl_pkg::DATA_W-1:0]    pwdata;
    logic [rbl_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    logic                          in_valid;
    logic                          in_stall;
    logic                          action;
    logic [7:0]                    data_byte;
    logic [rbl_pkg::BUF_LEN_W-1:0] buffer_length;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [1:0]                    status;
    logic [15:0]                   record_offset;
    logic [rbl_pkg::HDR_W-1:0]     header_size;
    logic [rbl_pkg::DSIZE_W-1:0]   data_size;

    resource_block_locator_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (action),
        .i_data_byte     (data_byte),
        .i_buffer_length (buffer_length),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_record_offset (record_offset),
        .o_header_size   (header_size),
        .o_data_size     (data_size)
    );

    // Clock: period 4
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model state, updated once per accepted item
    // ------------------------------------------------------------------
    logic [15:0] tag_reg    = rbl_pkg::TAG_RESET;
    logic [15:0] total_len  = '0;
    logic [15:0] scan_pos   = '0;
    t_scan       scan       = SCAN_IDLE;
    logic [1:0]  field_cnt  = '0;
    logic [15:0] rec_type   = '0;
    logic [8:0]  name_pad   = '0;
    logic [31:0] decl_size  = '0;
    logic [16:0] skip_cnt   = '0;
    logic [15:0] rec_start  = '0;

    rbl_pkg::t_result pending_verdicts[$];
    logic [7:0]       buf_bytes[$];

    int          items_sent     = 0;
    int          mismatch_count = 0;
    int          cfg_mismatches = 0;
    int          idle_cycles    = 0;

    // Traffic shaping shared with the receiver process
    bit          calm          = 1'b0;
    bit          gaps_on       = 1'b1;
    int          hold_requests = 0;
    int          holds_started = 0;
    int          hold_left     = 0;
    int          stall_burst   = 0;

    // Advance the parser model by one accepted item; queue a verdict if one falls due.
    task automatic advance_parser(input rbl_pkg::t_action act, input logic [7:0] b,
                                  input logic [15:0] len);
        logic [15:0]      pos;
        logic [33:0]      after;
        logic [33:0]      remain;
        logic [33:0]      pad;
        logic [33:0]      next_start;
        rbl_pkg::t_result v;
        bit               give;
        begin
            give     = 1'b0;
            v        = '0;
            v.status = rbl_pkg::STATUS_NONE;
            if (act == rbl_pkg::ACT_START) begin
                // A start drops any open buffer and clears all record fields
                total_len = len;
                scan_pos  = '0;
                rec_start = '0;
                field_cnt = '0;
                rec_type  = '0;
                name_pad  = '0;
                decl_size = '0;
                skip_cnt  = '0;
                if (len < rbl_pkg::MIN_RECORD)
                    give = 1'b1;
                else
                    scan = SCAN_SIG;
            end else if (scan != SCAN_IDLE) begin
                pos      = scan_pos;
                scan_pos = scan_pos + 16'd1;
                case (scan)
                    SCAN_SIG: begin
                        if (b != SIG_BYTES[field_cnt]) begin
                            give = 1'b1;
                        end else begin
                            field_cnt = field_cnt + 2'd1;
                            if (field_cnt == 2'd0)
                                scan = SCAN_TYPE;
                        end
                    end
                    SCAN_TYPE: begin
                        rec_type = {rec_type[7:0], b};
                        if (field_cnt == 2'd1) begin
                            field_cnt = '0;
                            scan      = SCAN_NAMELEN;
                        end else begin
                            field_cnt = field_cnt + 2'd1;
                        end
                    end
                    SCAN_NAMELEN: begin
                        // Length 255 pads to 256, hence nine bits
                        name_pad = ({1'b0, b} + 9'd2) & 9'h1FE;
                        after    = 34'(pos) + 34'(name_pad);
                        if (after + 34'd4 > 34'(total_len)) begin
                            give     = 1'b1;
                            v.status = rbl_pkg::STATUS_BAD;
                        end else begin
                            skip_cnt  = 17'(name_pad) - 17'd1;
                            field_cnt = '0;
                            scan      = SCAN_NAMESKIP;
                        end
                    end
                    SCAN_NAMESKIP: begin
                        if (skip_cnt != '0)
                            skip_cnt = skip_cnt - 17'd1;
                        if (skip_cnt == '0)
                            scan = SCAN_SIZE;
                    end
                    SCAN_SIZE: begin
                        decl_size = {decl_size[23:0], b};
                        if (field_cnt != 2'd3) begin
                            field_cnt = field_cnt + 2'd1;
                        end else begin
                            field_cnt = '0;
                            after     = 34'(pos) + 34'd1;
                            remain    = (after > 34'(total_len)) ? '0
                                                                 : 34'(total_len) - after;
                            if (34'(decl_size) > remain) begin
                                // Oversized data is caught ahead of the type match
                                give     = 1'b1;
                                v.status = rbl_pkg::STATUS_BAD;
                            end else if (rec_type == tag_reg) begin
                                give            = 1'b1;
                                v.status        = rbl_pkg::STATUS_FOUND;
                                v.record_offset = rec_start;
                                v.header_size   = rbl_pkg::HDR_W'(name_pad
                                                                  + rbl_pkg::HDR_FIXED);
                                v.data_size     = decl_size[rbl_pkg::DSIZE_W-1:0];
                            end else begin
                                pad        = 34'(decl_size) + 34'(decl_size[0]);
                                next_start = after + pad;
                                if (next_start + rbl_pkg::MIN_RECORD > 34'(total_len)) begin
                                    give = 1'b1;
                                end else if (pad == '0) begin
                                    rec_start = next_start[15:0];
                                    scan      = SCAN_SIG;
                                end else begin
                                    skip_cnt = pad[16:0];
                                    scan     = SCAN_DATASKIP;
                                end
                            end
                        end
                    end
                    SCAN_DATASKIP: begin
                        if (skip_cnt != '0)
                            skip_cnt = skip_cnt - 17'd1;
                        if (skip_cnt == '0) begin
                            rec_start = scan_pos;
                            field_cnt = '0;
                            scan      = SCAN_SIG;
                        end
                    end
                    default: scan = SCAN_IDLE;
                endcase
            end
            if (give) begin
                pending_verdicts = {pending_verdicts, v};
                scan = SCAN_IDLE;
            end
        end
    endtask

    task automatic note_mismatch(input bit had_want, input rbl_pkg::t_result want,
                                 input rbl_pkg::t_result got);
        begin
            mismatch_count++;
            if (mismatch_count + cfg_mismatches <= MAX_REPORTS) begin
                if (had_want)
                    $display("verdict mismatch: expected st %0d off %0d hdr %0d ds %0d,%s",
                             want.status, want.record_offset, want.header_size,
                             want.data_size, "");
                else
                    $display("verdict with nothing expected:");
                $display("    got st %0d off %0d hdr %0d ds %0d",
                         got.status, got.record_offset, got.header_size, got.data_size);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted verdict with the oldest one due
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            rbl_pkg::t_result got;
            rbl_pkg::t_result want;
            got.status        = rbl_pkg::t_status'(status);
            got.record_offset = record_offset;
            got.header_size   = header_size;
            got.data_size     = data_size;
            if (pending_verdicts.size() == 0) begin
                note_mismatch(1'b0, '0, got);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status || got.record_offset !== want.record_offset ||
                    got.header_size !== want.header_size || got.data_size !== want.data_size)
                    note_mismatch(1'b1, want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, a long hold-off on
    // request, and no stalls at all once the run turns calm
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_requests != holds_started) begin
            hold_left     = HOLD_OFF_CYCLES;
            holds_started = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (calm || !rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("resource_block_locator_unit_tb failed");
                $finish;
            end
        end
    end

    // Offer one item; enter and leave at a falling edge. Hold payload while stalled.
    task automatic send_item(input rbl_pkg::t_action act, input logic [7:0] b,
                             input logic [15:0] len);
        int gap;
        begin
            if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 16);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid      <= 1'b1;
            action        <= act;
            data_byte     <= b;
            buffer_length <= len;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            items_sent++;
            advance_parser(act, b, len);
            @(negedge clk);
        end
    endtask

    // Drop valid, wait for every verdict due, then let the pipeline settle.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_verdicts.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Write target_tag, then read it back in a back-to-back transfer.
    task automatic write_tag(input logic [15:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= TAG_ADDR;
            pwdata  <= {16'($urandom), value};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            tag_reg = value;
            @(negedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            if (prdata[15:0] !== value) begin
                cfg_mismatches++;
                if (mismatch_count + cfg_mismatches <= MAX_REPORTS)
                    $display("target_tag readback: expected %h, got %h", value, prdata[15:0]);
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Add one byte at the end of the buffer under construction.
    task automatic append_byte(input logic [7:0] b);
        begin
            buf_bytes = {buf_bytes, b};
        end
    endtask

    // Append one record: signature, type, padded name, size, padded data.
    // Declared sizes too large to be real get no data bytes.
    task automatic add_record(input logic [15:0] rtype, input logic [7:0] name_len,
                              input logic [31:0] dsize);
        begin
            foreach (SIG_BYTES[k]) append_byte(SIG_BYTES[k]);
            append_byte(rtype[15:8]);
            append_byte(rtype[7:0]);
            append_byte(name_len);
            repeat (int'(name_len)) append_byte(8'($urandom));
            if (!name_len[0]) append_byte(8'h00);
            append_byte(dsize[31:24]);
            append_byte(dsize[23:16]);
            append_byte(dsize[15:8]);
            append_byte(dsize[7:0]);
            if (dsize <= 32'd600) begin
                repeat (int'(dsize)) append_byte(8'($urandom));
                if (dsize[0]) append_byte(8'h00);
            end
        end
    endtask

    // Start a buffer and stream the built bytes until the verdict, or until abort_at.
    task automatic send_buffer(input logic [15:0] len, input int abort_at);
        begin
            send_item(rbl_pkg::ACT_START, 8'($urandom), len);
            for (int i = 0; i < buf_bytes.size(); i++) begin
                if (i == abort_at || scan == SCAN_IDLE) break;
                send_item(rbl_pkg::ACT_BYTE, buf_bytes[i], 16'($urandom));
            end
            // A few stray bytes after the verdict must be ignored
            if (!calm && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(rbl_pkg::ACT_BYTE, 8'($urandom), 16'($urandom));
        end
    endtask

    // Well-formed records with random content, with some cut, corrupted or aborted.
    task automatic send_random_buffer();
        int          n_rec;
        int          len_i;
        int          abort_at;
        int          mode;
        logic [15:0] rtype;
        logic [7:0]  name_len;
        logic [31:0] dsize;
        begin
            buf_bytes.delete();
            n_rec = $urandom_range(1, 3);
            for (int r = 0; r < n_rec; r++) begin
                if ((r == n_rec - 1 && $urandom_range(0, 1)) || $urandom_range(0, 5) == 0)
                    rtype = tag_reg;
                else
                    rtype = 16'($urandom);
                if ($urandom_range(0, 29) == 0)
                    name_len = 8'hFF;
                else if ($urandom_range(0, 29) == 0)
                    name_len = 8'($urandom);
                else
                    name_len = 8'($urandom_range(0, 5));
                if ($urandom_range(0, 11) == 0)
                    dsize = 32'($urandom) | 32'h0001_0000;
                else
                    dsize = 32'($urandom_range(0, 9));
                add_record(rtype, name_len, dsize);
            end
            mode = $urandom_range(0, 9);
            case (mode)
                0:       len_i = 65535;
                1:       len_i = int'(16'($urandom));
                2:       len_i = buf_bytes.size() - $urandom_range(1, 8);
                default: len_i = buf_bytes.size() + $urandom_range(0, 3);
            endcase
            if (len_i < 0) len_i = 0;
            if (len_i > 65535) len_i = 65535;
            if ($urandom_range(0, 9) == 0)
                buf_bytes[$urandom_range(0, buf_bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            abort_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, buf_bytes.size() - 1) : -1;
            gaps_on  = ($urandom_range(0, 3) != 0);
            send_buffer(16'(len_i), abort_at);
        end
    endtask

    // Random start length followed by a few random bytes.
    task automatic send_noise();
        begin
            send_item(rbl_pkg::ACT_START, 8'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 4))
                send_item(rbl_pkg::ACT_BYTE, 8'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lengths below 14 answer at once; a wrong signature byte ends the buffer.
    task automatic test_short_buffers();
        begin
            send_item(rbl_pkg::ACT_START, 8'h00, 16'd0);
            send_item(rbl_pkg::ACT_START, 8'hFF, 16'd13);
            send_item(rbl_pkg::ACT_START, 8'h00, 16'd14);
            send_item(rbl_pkg::ACT_BYTE, 8'hFF, 16'h0000);
            send_item(rbl_pkg::ACT_START, 8'hFF, 16'hFFFF);
            send_item(rbl_pkg::ACT_BYTE, 8'h38, 16'hFFFF);
            send_item(rbl_pkg::ACT_BYTE, 8'h42, 16'h0000);
            send_item(rbl_pkg::ACT_BYTE, 8'h00, 16'hFFFF);
        end
    endtask

    // Bytes with no buffer open produce nothing.
    task automatic test_idle_bytes();
        begin
            send_item(rbl_pkg::ACT_BYTE, 8'hFF, 16'hFFFF);
            send_item(rbl_pkg::ACT_BYTE, 8'h00, 16'h0000);
        end
    endtask

    // Found in a second record after padded odd data; odd data ending the buffer.
    task automatic test_found_records();
        begin
            buf_bytes.delete();
            add_record(16'h0000, 8'd0, 32'd1);
            add_record(rbl_pkg::TAG_RESET, 8'd0, 32'd0);
            send_buffer(16'd28, -1);
            buf_bytes.delete();
            add_record(16'h1234, 8'd1, 32'd3);
            send_buffer(16'(buf_bytes.size()), -1);
        end
    endtask

    // Name running past the end (length 255), and oversized data on a matching type.
    task automatic test_malformed();
        begin
            buf_bytes.delete();
            add_record(rbl_pkg::TAG_RESET, 8'hFF, 32'd0);
            send_buffer(16'd20, -1);
            buf_bytes.delete();
            add_record(rbl_pkg::TAG_RESET, 8'd0, 32'hFFFF_FFFF);
            send_buffer(16'hFFFF, -1);
        end
    endtask

    // A start in mid-buffer drops the open buffer without a verdict.
    task automatic test_start_while_parsing();
        begin
            buf_bytes.delete();
            add_record(rbl_pkg::TAG_RESET, 8'd2, 32'd4);
            send_buffer(16'd100, 5);
            send_item(rbl_pkg::ACT_START, 8'h5A, 16'd5);
        end
    endtask

    // Random buffers under one target_tag setting.
    task automatic test_random_records(input logic [15:0] tag_value, input int item_budget);
        int items_goal;
        begin
            wait_drained();
            write_tag(tag_value);
            items_goal = items_sent + item_budget;
            while (items_sent < items_goal) begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                else
                    send_random_buffer();
            end
        end
    endtask

    // Hold the receiver off while verdict-heavy items keep coming, so the input stalls.
    task automatic test_backpressure();
        begin
            wait_drained();
            gaps_on = 1'b0;
            hold_requests++;
            repeat (40)
                send_item(rbl_pkg::ACT_START, 8'($urandom), 16'($urandom_range(0, 13)));
            send_random_buffer();
        end
    endtask

    // Last stretch with no idling on either side.
    task automatic test_calm_tail();
        begin
            calm = 1'b1;
            repeat (3) send_random_buffer();
        end
    endtask

    initial begin
        // Drive every input to a known value from time zero
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        action        = rbl_pkg::ACT_START;
        data_byte     = '0;
        buffer_length = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_buffers();
        test_idle_bytes();
        test_found_records();
        test_malformed();
        test_start_while_parsing();
        test_random_records(16'h0000, 50);
        test_random_records(16'hFFFF, 50);
        test_random_records(16'($urandom), 50);
        test_random_records(rbl_pkg::TAG_RESET, 50);
        test_backpressure();
        test_calm_tail();

        // Drain the last verdicts; a lost one trips the watchdog
        wait_drained();
        if (mismatch_count == 0 && cfg_mismatches == 0)
            $display("resource_block_locator_unit_tb passed");
        else
            $display("resource_block_locator_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/rbl_pkg.sv
design/rbl_cfg.sv
design/rbl_in_stage.sv
design/rbl_parser.sv
design/resource_block_locator_unit.sv
tb/resource_block_locator_unit_tb.sv
